@@ design/qdlf_pkg.sv @@
// Shared types, constants and helpers for the quadratic distortion fit.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package qdlf_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PAIRS_DEF  = 1024;
	localparam int COORD_BITS_DEF = 13;

	// Fixed field and datapath widths
	localparam int ORG_W   = 15;   // origin registers
	localparam int CRD_W   = 17;   // shifted coordinate, signed
	localparam int RR_W    = 32;   // squared radius, unsigned
	localparam int MUL_W   = 33;   // pair multiplier operands, signed
	localparam int PRD_W   = 66;   // pair multiplier product
	localparam int Z_W     = 48;   // radial term before flooring
	localparam int ZSHIFT  = 20;
	localparam int ZT_W    = Z_W - ZSHIFT;
	localparam int PAIR_W  = 11;
	localparam int SZ_W    = 37;   // sum of Z
	localparam int SZZ_W   = 64;   // sum of Z squared
	localparam int SD_W    = 27;   // sum of d
	localparam int SZR_W   = 53;   // sum of Z*d
	localparam int WIDE_W  = 128;  // solve word
	localparam int B_W     = 40;   // solve multiplier operand, signed
	localparam int CNT_W   = 7;    // iteration counter
	localparam int SHX_W   = 48;
	localparam int ALPHA_W = 64;
	localparam int SHIFT_Q = 16;
	localparam int ALPHA_Q = 40;

	// Configuration register indexes
	localparam logic REG_ORIGIN_ROW = 1'b0;
	localparam logic REG_ORIGIN_COL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAIR,
		ST_MUL_LOAD,
		ST_MUL_RUN,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_DIV_HALF,
		ST_DIV_ITER,
		ST_DIV_STORE,
		ST_OUT
	} fsm_t;

	// Per-pair multiplier schedule
	typedef enum logic [3:0] {
		PS_X1SQ,
		PS_Y1SQ,
		PS_X2SQ,
		PS_Y2SQ,
		PS_RX1,
		PS_RY1,
		PS_RX2,
		PS_RY2,
		PS_ZXSQ,
		PS_ZYSQ,
		PS_ZXD,
		PS_ZYD,
		PS_FIN
	} pstep_t;

	// Solve multiply-accumulate schedule
	typedef enum logic [3:0] {
		OP_M_NZZ,
		OP_M_XX,
		OP_M_YY,
		OP_NA_NZR,
		OP_NA_XD,
		OP_NA_YD,
		OP_DEN,
		OP_EA_M,
		OP_EA_N,
		OP_EB_M,
		OP_EB_N
	} op_t;

	typedef enum logic [1:0] {
		DV_X,
		DV_Y,
		DV_A
	} dsel_t;

	// Clamp a magnitude to a signed w-bit range, then apply the sign
	function automatic logic [63:0] sat_f(input logic [WIDE_W-1:0] mag,
		input logic neg, input int w);
		logic [WIDE_W-1:0] lim;
		logic [WIDE_W-1:0] m;
		lim = (WIDE_W'(1) << (w - 1)) - WIDE_W'(1);
		if (neg) begin
			lim = lim + WIDE_W'(1);
		end
		m = (mag > lim) ? lim : mag;
		sat_f = neg ? 64'(-m) : 64'(m);
	endfunction

endpackage

`default_nettype wire

@@ design/quadratic_distortion_lsq_fit.sv @@
// Top level of the quadratic distortion least-squares fit.
// Depends on qdlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Fits shift x, shift y and a cubic radial distortion alpha to matched star
// pairs. Each request carries one pair; both positions are moved by the chip
// origin, the radial terms are formed and floored by 2^20, and the normal
// equation sums are updated. After its accept cycle a pair runs through 13
// steps of the one 33x33 multiplier; a pair arriving at capacity is dropped
// and only flags overflow. The pair marked last starts the solve: eleven
// multiply-accumulates on the 128-bit adder, then three rounded divisions on
// the same adder (skipped when the system is singular), then the result is
// placed in the output register and all sums clear. in_stall is high
// throughout a pair or a solve; a finished result waits in the output
// register and does not hold the input side, except that the next solve
// cannot hand over until it is taken. The user must write the origin registers
// through cfg_we/cfg_index/cfg_data only while idle; this is not enforced.
module quadratic_distortion_lsq_fit #(
	parameter int MAX_PAIRS  = qdlf_pkg::MAX_PAIRS_DEF,
	parameter int COORD_BITS = qdlf_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_index,
	input  wire logic [qdlf_pkg::ORG_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [COORD_BITS-1:0]              row_first,
	input  wire logic [COORD_BITS-1:0]              col_first,
	input  wire logic [COORD_BITS-1:0]              row_second,
	input  wire logic [COORD_BITS-1:0]              col_second,
	input  wire logic                               last_pair,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [qdlf_pkg::SHX_W-1:0]       shift_x,
	output logic signed [qdlf_pkg::SHX_W-1:0]       shift_y,
	output logic signed [qdlf_pkg::ALPHA_W-1:0]     alpha_scaled,
	output logic [qdlf_pkg::PAIR_W-1:0]             pair_count,
	output logic                                    singular,
	output logic                                    overflow
);
	import qdlf_pkg::*;

	localparam int PAD_W = CRD_W - COORD_BITS;

	// control
	fsm_t   state_q, state_d;
	pstep_t pst_q;
	op_t    op_q;
	dsel_t  dsel_q;
	logic [CNT_W-1:0] cnt_q;
	logic   last_q;
	logic   accept;
	logic   full;

	// configuration
	logic signed [ORG_W-1:0] org_row_q, org_col_q;

	// pair datapath
	logic signed [CRD_W-1:0] x1_q, y1_q, x2_q, y2_q, dx_q, dy_q;
	logic signed [CRD_W-1:0] x1_n, y1_n, x2_n, y2_n;
	logic [RR_W-1:0]         rr1_q, rr2_q;
	logic signed [Z_W-1:0]   t_q, u_q, z_n;
	logic signed [ZT_W-1:0]  zx_q, zy_q;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PRD_W-1:0] p_q;

	// normal-equation sums
	logic [PAIR_W-1:0]       pairs_q;
	logic signed [SZ_W-1:0]  acc_zx_q, acc_zy_q;
	logic [SZZ_W-1:0]        acc_zz_q;
	logic signed [SD_W-1:0]  acc_dx_q, acc_dy_q;
	logic signed [SZR_W-1:0] acc_zr_q;
	logic                    dropped_q;

	// solve datapath
	logic signed [WIDE_W-1:0] m_q, na_q, den_q, ea_q, eb_q;
	logic signed [WIDE_W-1:0] aw_q, op_a, dest_cur, div_n, div_d;
	logic signed [B_W-1:0]    op_b;
	logic [B_W-1:0]           bw_q;
	logic                     op_sub, mneg_q, sgn_q;
	logic [WIDE_W-1:0]        nq_q, dm_q, r_q;
	logic [WIDE_W:0]          ad_x, ad_y, pre;
	logic                     ad_cin;
	logic [WIDE_W+1:0]        ad_sum;
	logic [SHX_W-1:0]         res_x_q, res_y_q;
	logic [ALPHA_W-1:0]       res_a_q;

	assign accept = in_valid && !in_stall;
	assign full   = (pairs_q == PAIR_W'(MAX_PAIRS));

	// coordinates moved by the origin
	assign y1_n = $signed({{PAD_W{1'b0}}, row_first})  + CRD_W'(org_row_q);
	assign x1_n = $signed({{PAD_W{1'b0}}, col_first})  + CRD_W'(org_col_q);
	assign y2_n = $signed({{PAD_W{1'b0}}, row_second}) + CRD_W'(org_row_q);
	assign x2_n = $signed({{PAD_W{1'b0}}, col_second}) + CRD_W'(org_col_q);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!full) begin
						state_d = ST_PAIR;
					end else if (last_pair) begin
						state_d = ST_MUL_LOAD;
					end
				end
			end
			ST_PAIR: begin
				if (pst_q == PS_FIN) begin
					state_d = last_q ? ST_MUL_LOAD : ST_IDLE;
				end
			end
			ST_MUL_LOAD: state_d = ST_MUL_RUN;
			ST_MUL_RUN: begin
				if (cnt_q == CNT_W'(B_W - 1)) begin
					if (op_q != OP_EB_N) begin
						state_d = ST_MUL_LOAD;
					end else if (den_q == '0) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_DIV_NUM;
					end
				end
			end
			ST_DIV_NUM:  state_d = ST_DIV_DEN;
			ST_DIV_DEN:  state_d = ST_DIV_HALF;
			ST_DIV_HALF: state_d = ST_DIV_ITER;
			ST_DIV_ITER: begin
				if (cnt_q == CNT_W'(WIDE_W - 1)) begin
					state_d = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: state_d = (dsel_q == DV_A) ? ST_OUT : ST_DIV_NUM;
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	// ---------------- pair multiplier operands ----------------
	always_comb begin
		ma = '0;
		mb = '0;
		case (pst_q)
			PS_X1SQ: begin ma = MUL_W'(x1_q); mb = MUL_W'(x1_q); end
			PS_Y1SQ: begin ma = MUL_W'(y1_q); mb = MUL_W'(y1_q); end
			PS_X2SQ: begin ma = MUL_W'(x2_q); mb = MUL_W'(x2_q); end
			PS_Y2SQ: begin ma = MUL_W'(y2_q); mb = MUL_W'(y2_q); end
			PS_RX1:  begin ma = $signed({1'b0, rr1_q}); mb = MUL_W'(x1_q); end
			PS_RY1:  begin ma = $signed({1'b0, rr1_q}); mb = MUL_W'(y1_q); end
			PS_RX2:  begin ma = $signed({1'b0, rr2_q}); mb = MUL_W'(x2_q); end
			PS_RY2:  begin ma = $signed({1'b0, rr2_q}); mb = MUL_W'(y2_q); end
			PS_ZXSQ: begin ma = MUL_W'(zx_q); mb = MUL_W'(zx_q); end
			PS_ZYSQ: begin ma = MUL_W'(zy_q); mb = MUL_W'(zy_q); end
			PS_ZXD:  begin ma = MUL_W'(zx_q); mb = MUL_W'(dx_q); end
			PS_ZYD:  begin ma = MUL_W'(zy_q); mb = MUL_W'(dy_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// radial term: product minus the first-exposure term held in t or u
	assign z_n = p_q[Z_W-1:0] - ((pst_q == PS_RY2) ? t_q : u_q);

	// ---------------- solve operand selection ----------------
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (op_q)
			OP_M_NZZ:  begin op_a = WIDE_W'($signed({1'b0, acc_zz_q}));
				op_b = $signed(B_W'(pairs_q)); end
			OP_M_XX:   begin op_a = WIDE_W'(acc_zx_q); op_b = B_W'(acc_zx_q);
				op_sub = 1'b1; end
			OP_M_YY:   begin op_a = WIDE_W'(acc_zy_q); op_b = B_W'(acc_zy_q);
				op_sub = 1'b1; end
			OP_NA_NZR: begin op_a = WIDE_W'(acc_zr_q);
				op_b = $signed(B_W'(pairs_q)); end
			OP_NA_XD:  begin op_a = WIDE_W'(acc_zx_q); op_b = B_W'(acc_dx_q);
				op_sub = 1'b1; end
			OP_NA_YD:  begin op_a = WIDE_W'(acc_zy_q); op_b = B_W'(acc_dy_q);
				op_sub = 1'b1; end
			OP_DEN:    begin op_a = m_q; op_b = $signed(B_W'(pairs_q)); end
			OP_EA_M:   begin op_a = m_q; op_b = B_W'(acc_dx_q); end
			OP_EA_N:   begin op_a = na_q; op_b = B_W'(acc_zx_q); op_sub = 1'b1; end
			OP_EB_M:   begin op_a = m_q; op_b = B_W'(acc_dy_q); end
			OP_EB_N:   begin op_a = na_q; op_b = B_W'(acc_zy_q); op_sub = 1'b1; end
			default:   begin op_a = '0; op_b = '0; op_sub = 1'b0; end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_M_NZZ, OP_M_XX, OP_M_YY:     dest_cur = m_q;
			OP_NA_NZR, OP_NA_XD, OP_NA_YD:  dest_cur = na_q;
			OP_DEN:                          dest_cur = den_q;
			OP_EA_M, OP_EA_N:               dest_cur = ea_q;
			default:                         dest_cur = eb_q;
		endcase
	end

	// division operands
	always_comb begin
		case (dsel_q)
			DV_X:    begin div_n = ea_q <<< SHIFT_Q; div_d = den_q; end
			DV_Y:    begin div_n = eb_q <<< SHIFT_Q; div_d = den_q; end
			default: begin div_n = na_q <<< ALPHA_Q; div_d = m_q; end
		endcase
	end

	// ---------------- the shared 128-bit adder ----------------
	assign pre = {r_q, nq_q[WIDE_W-1]};

	always_comb begin
		ad_x   = '0;
		ad_y   = '0;
		ad_cin = 1'b0;
		case (state_q)
			ST_MUL_RUN: begin
				ad_x   = {1'b0, dest_cur};
				ad_y   = mneg_q ? ~{1'b0, aw_q} : {1'b0, aw_q};
				ad_cin = mneg_q;
			end
			ST_DIV_NUM: begin
				ad_y   = div_n[WIDE_W-1] ? ~{1'b0, div_n} : {1'b0, div_n};
				ad_cin = div_n[WIDE_W-1];
			end
			ST_DIV_DEN: begin
				ad_y   = div_d[WIDE_W-1] ? ~{1'b0, div_d} : {1'b0, div_d};
				ad_cin = div_d[WIDE_W-1];
			end
			ST_DIV_HALF: begin
				ad_x = {1'b0, nq_q};
				ad_y = {2'b00, dm_q[WIDE_W-1:1]};
			end
			ST_DIV_ITER: begin
				ad_x   = pre;
				ad_y   = ~{1'b0, dm_q};
				ad_cin = 1'b1;
			end
			default: begin
				ad_x   = '0;
				ad_y   = '0;
				ad_cin = 1'b0;
			end
		endcase
	end

	assign ad_sum = {1'b0, ad_x} + {1'b0, ad_y} + (WIDE_W+2)'(ad_cin);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pst_q     <= PS_X1SQ;
			op_q      <= OP_M_NZZ;
			dsel_q    <= DV_X;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			org_row_q <= '0;
			org_col_q <= '0;
			pairs_q   <= '0;
			acc_zx_q  <= '0;
			acc_zy_q  <= '0;
			acc_zz_q  <= '0;
			acc_dx_q  <= '0;
			acc_dy_q  <= '0;
			acc_zr_q  <= '0;
			dropped_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_ROW: org_row_q <= $signed(cfg_data);
					REG_ORIGIN_COL: org_col_q <= $signed(cfg_data);
					default: ;
				endcase
			end

			// a new result may replace one taken at the same edge
			if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_pair;
						pst_q  <= PS_X1SQ;
						if (full) begin
							dropped_q <= 1'b1;
						end
					end
					op_q <= OP_M_NZZ;
				end
				ST_PAIR: begin
					pst_q <= pstep_t'(pst_q + 4'd1);
					case (pst_q)
						PS_ZYSQ: begin
							acc_zz_q <= acc_zz_q + SZZ_W'(p_q);
							acc_zx_q <= acc_zx_q + SZ_W'(zx_q);
						end
						PS_ZXD: begin
							acc_zz_q <= acc_zz_q + SZZ_W'(p_q);
							acc_zy_q <= acc_zy_q + SZ_W'(zy_q);
						end
						PS_ZYD: acc_zr_q <= acc_zr_q + SZR_W'(p_q);
						PS_FIN: begin
							acc_zr_q <= acc_zr_q + SZR_W'(p_q);
							acc_dx_q <= acc_dx_q + SD_W'(dx_q);
							acc_dy_q <= acc_dy_q + SD_W'(dy_q);
							pairs_q  <= pairs_q + PAIR_W'(1);
						end
						default: ;
					endcase
					op_q <= OP_M_NZZ;
				end
				ST_MUL_LOAD: cnt_q <= '0;
				ST_MUL_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(B_W - 1) && op_q != OP_EB_N) begin
						op_q <= op_t'(op_q + 4'd1);
					end
					dsel_q <= DV_X;
				end
				ST_DIV_HALF: cnt_q <= '0;
				ST_DIV_ITER: cnt_q <= cnt_q + CNT_W'(1);
				ST_DIV_STORE: begin
					if (dsel_q != DV_A) begin
						dsel_q <= dsel_t'(dsel_q + 2'd1);
					end
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						// the fit is handed over: start a fresh list
						pairs_q   <= '0;
						acc_zx_q  <= '0;
						acc_zy_q  <= '0;
						acc_zz_q  <= '0;
						acc_dx_q  <= '0;
						acc_dy_q  <= '0;
						acc_zr_q  <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			x1_q <= x1_n;
			y1_q <= y1_n;
			x2_q <= x2_n;
			y2_q <= y2_n;
			dx_q <= x2_n - x1_n;
			dy_q <= y2_n - y1_n;
		end

		if (state_q == ST_PAIR) begin
			p_q <= ma * mb;
			case (pst_q)
				PS_Y1SQ: t_q   <= p_q[Z_W-1:0];
				PS_X2SQ: rr1_q <= RR_W'(t_q) + p_q[RR_W-1:0];
				PS_Y2SQ: t_q   <= p_q[Z_W-1:0];
				PS_RX1:  rr2_q <= RR_W'(t_q) + p_q[RR_W-1:0];
				PS_RY1:  t_q   <= p_q[Z_W-1:0];
				PS_RX2:  u_q   <= p_q[Z_W-1:0];
				// arithmetic shift right by 20 floors towards minus infinity
				PS_RY2:  zx_q  <= z_n[Z_W-1:ZSHIFT];
				PS_ZXSQ: zy_q  <= z_n[Z_W-1:ZSHIFT];
				default: ;
			endcase
		end

		// first solve op: clear the five accumulating words
		if ((state_q == ST_IDLE || state_q == ST_PAIR) && state_d == ST_MUL_LOAD) begin
			m_q   <= '0;
			na_q  <= '0;
			den_q <= '0;
			ea_q  <= '0;
			eb_q  <= '0;
		end

		case (state_q)
			ST_MUL_LOAD: begin
				aw_q   <= op_a;
				bw_q   <= op_b[B_W-1] ? B_W'(-op_b) : B_W'(op_b);
				mneg_q <= op_sub ^ op_b[B_W-1];
			end
			ST_MUL_RUN: begin
				aw_q <= aw_q <<< 1;
				bw_q <= bw_q >> 1;
				if (bw_q[0]) begin
					case (op_q)
						OP_M_NZZ, OP_M_XX, OP_M_YY:    m_q  <= ad_sum[WIDE_W-1:0];
						OP_NA_NZR, OP_NA_XD, OP_NA_YD: na_q <= ad_sum[WIDE_W-1:0];
						OP_DEN:                         den_q <= ad_sum[WIDE_W-1:0];
						OP_EA_M, OP_EA_N:              ea_q <= ad_sum[WIDE_W-1:0];
						default:                        eb_q <= ad_sum[WIDE_W-1:0];
					endcase
				end
			end
			ST_DIV_NUM: begin
				nq_q  <= ad_sum[WIDE_W-1:0];
				sgn_q <= div_n[WIDE_W-1] ^ div_d[WIDE_W-1];
			end
			ST_DIV_DEN:  dm_q <= ad_sum[WIDE_W-1:0];
			ST_DIV_HALF: begin
				// round to nearest, ties away from zero
				nq_q <= ad_sum[WIDE_W-1:0];
				r_q  <= '0;
			end
			ST_DIV_ITER: begin
				if (ad_sum[WIDE_W+1]) begin
					r_q  <= ad_sum[WIDE_W-1:0];
					nq_q <= {nq_q[WIDE_W-2:0], 1'b1};
				end else begin
					r_q  <= pre[WIDE_W-1:0];
					nq_q <= {nq_q[WIDE_W-2:0], 1'b0};
				end
			end
			ST_DIV_STORE: begin
				case (dsel_q)
					DV_X:    res_x_q <= SHX_W'(sat_f(nq_q, sgn_q, SHX_W));
					DV_Y:    res_y_q <= SHX_W'(sat_f(nq_q, sgn_q, SHX_W));
					default: res_a_q <= sat_f(nq_q, sgn_q, ALPHA_W);
				endcase
			end
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					singular     <= (den_q == '0);
					shift_x      <= (den_q == '0) ? '0 : $signed(res_x_q);
					shift_y      <= (den_q == '0) ? '0 : $signed(res_y_q);
					alpha_scaled <= (den_q == '0) ? '0 : $signed(res_a_q);
					pair_count   <= pairs_q;
					overflow     <= dropped_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ design/qdlf_chk.sv @@
// Port-level checker for the quadratic distortion fit, bound to the top level.
// Depends on qdlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdlf_chk #(
	parameter int MAX_PAIRS  = qdlf_pkg::MAX_PAIRS_DEF,
	parameter int COORD_BITS = qdlf_pkg::COORD_BITS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           last_pair,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [qdlf_pkg::SHX_W-1:0]     shift_x,
	input wire logic [qdlf_pkg::SHX_W-1:0]     shift_y,
	input wire logic [qdlf_pkg::ALPHA_W-1:0]   alpha_scaled,
	input wire logic [qdlf_pkg::PAIR_W-1:0]    pair_count,
	input wire logic                           singular
);
	import qdlf_pkg::*;

	// a last pair always starts work that holds the input side
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_pair |=> in_stall)
		else $error("last pair accepted without starting the solve");

	// results appear only at the end of a solve
	a_out_from_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while idle");

	// a singular fit reports zeros
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> shift_x == '0 && shift_y == '0 && alpha_scaled == '0)
		else $error("singular result with non-zero fit values");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pair_count <= PAIR_W'(MAX_PAIRS))
		else $error("pair count beyond capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(alpha_scaled) && $stable(shift_x))
		else $error("stalled result changed");

endmodule

bind quadratic_distortion_lsq_fit qdlf_chk #(
	.MAX_PAIRS  (MAX_PAIRS),
	.COORD_BITS (COORD_BITS)
) u_qdlf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_pair    (last_pair),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.shift_x      (shift_x),
	.shift_y      (shift_y),
	.alpha_scaled (alpha_scaled),
	.pair_count   (pair_count),
	.singular     (singular)
);

`default_nettype wire
